### src/cavg_pkg.sv
// Shared types, constants and helper functions for the circle arc vertex generator.
package cavg_pkg;

    localparam int FRAC_BITS = 16;
    localparam int MAX_DEPTH = 8;
    localparam int COORD_W   = 18;
    localparam int IDX_W     = 12;
    localparam int LEAF_W    = 7;

    // Register indexes on the configuration port.
    localparam logic REG_RADIUS  = 1'b0;
    localparam logic REG_OPTIONS = 1'b1;

    // Per-level midpoint divisors.
    localparam logic [16:0] LEVEL_DIV [MAX_DEPTH] = '{
        17'h16a09, 17'h1d906, 17'h1f629, 17'h1fd88,
        17'h1ff62, 17'h1ffd8, 17'h1fff6, 17'h1fffd
    };

    // Reciprocals floor(2^34 / divisor), all below 2^18.
    localparam logic [63:0] RECIP_ONE = 64'd1 << 34;
    localparam logic [17:0] LEVEL_RECIP [MAX_DEPTH] = '{
        18'(RECIP_ONE / 64'h16a09), 18'(RECIP_ONE / 64'h1d906),
        18'(RECIP_ONE / 64'h1f629), 18'(RECIP_ONE / 64'h1fd88),
        18'(RECIP_ONE / 64'h1ff62), 18'(RECIP_ONE / 64'h1ffd8),
        18'(RECIP_ONE / 64'h1fff6), 18'(RECIP_ONE / 64'h1fffd)
    };

    // Configuration as seen by the datapath.
    typedef struct packed {
        logic [31:0] radius;
        logic        dup;
        logic        ends;
        logic        noscale;
        logic [3:0]  depth;
    } cfg_t;

    // One vertex request travelling down the subdivision pipeline.
    typedef struct packed {
        logic signed [COORD_W-1:0] x1;
        logic signed [COORD_W-1:0] y1;
        logic signed [COORD_W-1:0] x2;
        logic signed [COORD_W-1:0] y2;
        logic [LEAF_W-1:0]         leaf;
        logic                      take_mid;
        logic                      bypass;
        logic                      is_final;
        logic                      past_end;
    } item_t;

    // Quarter corners (1,0),(0,1),(-1,0),(0,-1),(1,0).
    function automatic logic signed [COORD_W-1:0] corner_x(input logic [2:0] k);
        logic signed [COORD_W-1:0] v;
        case (k)
            3'd0, 3'd4: v = 18'sd65536;
            3'd2:       v = -18'sd65536;
            default:    v = '0;
        endcase
        return v;
    endfunction

    function automatic logic signed [COORD_W-1:0] corner_y(input logic [2:0] k);
        logic signed [COORD_W-1:0] v;
        case (k)
            3'd1:    v = 18'sd65536;
            3'd3:    v = -18'sd65536;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

### src/cavg_cfg.sv
// APB configuration registers and the subdivision depth derived from the radius.
module cavg_cfg (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output cavg_pkg::cfg_t     cfg
);

    logic [31:0] radius_reg;
    logic [2:0]  options_reg;
    logic        wr_en;
    logic [4:0]  lg;
    logic [15:0] ir;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    // Register writes take effect in the access phase.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg  <= 32'h0001_0000;
            options_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (paddr[2])
                cavg_pkg::REG_RADIUS:  radius_reg  <= pwdata;
                cavg_pkg::REG_OPTIONS: options_reg <= pwdata[2:0];
                default: ;
            endcase
        end
    end

    // Read back.
    always_comb
    begin
        unique case (paddr[2])
            cavg_pkg::REG_RADIUS:  prdata = radius_reg;
            cavg_pkg::REG_OPTIONS: prdata = {29'd0, options_reg};
            default:               prdata = '0;
        endcase
    end

    // Depth is floor(log2 of the integer radius) minus one, clamped to 1..8.
    assign ir = radius_reg[31:16];
    always_comb
    begin
        lg = '0;
        for (int i = 0; i < 16; i++)
        begin
            if (ir[i])
            begin
                lg = 5'(i);
            end
        end
    end

    always_comb
    begin
        cfg.radius  = radius_reg;
        cfg.dup     = options_reg[0];
        cfg.ends    = options_reg[1];
        cfg.noscale = options_reg[2];
        if (lg <= 5'd2)
        begin
            cfg.depth = 4'd1;
        end
        else if (lg >= 5'd9)
        begin
            cfg.depth = 4'd8;
        end
        else
        begin
            cfg.depth = 4'(lg - 5'd1);
        end
    end

endmodule

### src/cavg_front.sv
// Index decode: list length, quarter and leaf selection, and starting end points.
module cavg_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          adv,
    input  cavg_pkg::cfg_t                cfg,
    input  logic                          in_valid,
    input  logic [cavg_pkg::IDX_W-1:0]    vertex_index,
    output logic [cavg_pkg::IDX_W-1:0]    total,
    output logic                          out_valid,
    output cavg_pkg::item_t               out_item
);

    logic [8:0]  leafpts;
    logic [8:0]  unit;
    logic [11:0] base_total;
    logic [11:0] b;

    logic        s0_valid_reg;
    logic [11:0] s0_b_reg;
    logic        s0_final_reg;
    logic        s0_past_reg;

    logic [11:0] u1, u2, u3, u4;
    logic [2:0]  q;
    logic [11:0] qoff;
    logic [8:0]  r;
    cavg_pkg::item_t item_next;
    cavg_pkg::item_t item_reg;
    logic            valid_reg;

    // List geometry from the configuration.
    assign leafpts    = 9'd1 << cfg.depth;
    assign unit       = leafpts + {8'd0, cfg.ends};
    assign base_total = {1'b0, unit, 2'b00} + 12'd1;
    assign total      = cfg.dup ? {base_total[10:0], 1'b0} : base_total;
    assign b          = cfg.dup ? {1'b0, vertex_index[11:1]} : vertex_index;

    // First stage: position in the base list and end-of-list flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s0_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s0_b_reg     <= b;
            s0_final_reg <= vertex_index == total - 12'd1;
            s0_past_reg  <= vertex_index >= total;
        end
    end

    // Second stage: quarter by comparison against multiples of the arc length.
    assign u1 = {3'd0, unit};
    assign u2 = {2'd0, unit, 1'b0};
    assign u3 = u1 + u2;
    assign u4 = {1'b0, unit, 2'b00};

    always_comb
    begin
        if (s0_b_reg >= u4)
        begin
            q = 3'd4; qoff = u4;
        end
        else if (s0_b_reg >= u3)
        begin
            q = 3'd3; qoff = u3;
        end
        else if (s0_b_reg >= u2)
        begin
            q = 3'd2; qoff = u2;
        end
        else if (s0_b_reg >= u1)
        begin
            q = 3'd1; qoff = u1;
        end
        else
        begin
            q = 3'd0; qoff = '0;
        end
        r = 9'(s0_b_reg - qoff);
    end

    always_comb
    begin
        item_next          = '0;
        item_next.is_final = s0_final_reg;
        item_next.past_end = s0_past_reg;
        item_next.leaf     = r[7:1];
        item_next.take_mid = r[0];
        if (s0_past_reg)
        begin
            item_next.bypass = 1'b1;
        end
        else if (q == 3'd4)
        begin
            item_next.bypass = 1'b1;
            item_next.x1     = cavg_pkg::corner_x(3'd4);
            item_next.y1     = cavg_pkg::corner_y(3'd4);
        end
        else if (r >= leafpts)
        begin
            // Quarter end point added after the arc.
            item_next.bypass = 1'b1;
            item_next.x1     = cavg_pkg::corner_x(q + 3'd1);
            item_next.y1     = cavg_pkg::corner_y(q + 3'd1);
        end
        else
        begin
            item_next.x1 = cavg_pkg::corner_x(q);
            item_next.y1 = cavg_pkg::corner_y(q);
            item_next.x2 = cavg_pkg::corner_x(q + 3'd1);
            item_next.y2 = cavg_pkg::corner_y(q + 3'd1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= s0_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

### src/cavg_level.sv
// One subdivision level: midpoint by reciprocal multiply with correction, then leaf choice.
module cavg_level (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  adv,
    input  logic [2:0]            level,
    input  logic [3:0]            depth,
    input  logic                  in_valid,
    input  cavg_pkg::item_t       in_item,
    output logic                  out_valid,
    output cavg_pkg::item_t       out_item
);

    logic [17:0] recip;
    logic [16:0] kdiv;

    logic signed [18:0] sum_x, sum_y;
    logic [17:0] abs_x, abs_y;

    // Stage A registers.
    logic            a_valid_reg;
    cavg_pkg::item_t a_item_reg;
    logic [17:0]     a_abs_x_reg, a_abs_y_reg;
    logic            a_sx_reg, a_sy_reg;
    logic [35:0]     a_px_reg, a_py_reg;

    // Stage B registers.
    logic            b_valid_reg;
    cavg_pkg::item_t b_item_reg;
    logic [17:0]     b_abs_x_reg, b_abs_y_reg;
    logic            b_sx_reg, b_sy_reg;
    logic [17:0]     b_qx_reg, b_qy_reg;
    logic [34:0]     b_pkx_reg, b_pky_reg;

    logic [17:0] q0x, q0y;
    logic [34:0] rem_x, rem_y;
    logic [17:0] qx, qy;
    logic signed [17:0] mx, my;
    logic        active, last, pick;
    logic [3:0]  bit_sel;
    cavg_pkg::item_t c_item_next;
    logic            c_valid_reg;
    cavg_pkg::item_t c_item_reg;

    assign recip = cavg_pkg::LEVEL_RECIP[level];
    assign kdiv  = cavg_pkg::LEVEL_DIV[level];

    // Stage A: end-point sums and reciprocal products on the magnitudes.
    assign sum_x = 19'(in_item.x1) + 19'(in_item.x2);
    assign sum_y = 19'(in_item.y1) + 19'(in_item.y2);
    assign abs_x = sum_x[18] ? 18'(-sum_x) : sum_x[17:0];
    assign abs_y = sum_y[18] ? 18'(-sum_y) : sum_y[17:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_item_reg  <= in_item;
            a_abs_x_reg <= abs_x;
            a_abs_y_reg <= abs_y;
            a_sx_reg    <= sum_x[18];
            a_sy_reg    <= sum_y[18];
            a_px_reg    <= abs_x * recip;
            a_py_reg    <= abs_y * recip;
        end
    end

    // Stage B: estimated quotient, one low at most, and its back product.
    assign q0x = a_px_reg[35:18];
    assign q0y = a_py_reg[35:18];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b_item_reg  <= a_item_reg;
            b_abs_x_reg <= a_abs_x_reg;
            b_abs_y_reg <= a_abs_y_reg;
            b_sx_reg    <= a_sx_reg;
            b_sy_reg    <= a_sy_reg;
            b_qx_reg    <= q0x;
            b_qy_reg    <= q0y;
            b_pkx_reg   <= 35'(q0x * kdiv);
            b_pky_reg   <= 35'(q0y * kdiv);
        end
    end

    // Stage C: correct the quotient, restore the sign, and narrow the arc.
    assign rem_x = {1'b0, b_abs_x_reg, 16'd0} - b_pkx_reg;
    assign rem_y = {1'b0, b_abs_y_reg, 16'd0} - b_pky_reg;
    assign qx    = (rem_x >= 35'(kdiv)) ? b_qx_reg + 18'd1 : b_qx_reg;
    assign qy    = (rem_y >= 35'(kdiv)) ? b_qy_reg + 18'd1 : b_qy_reg;
    assign mx    = b_sx_reg ? -$signed(qx) : $signed(qx);
    assign my    = b_sy_reg ? -$signed(qy) : $signed(qy);

    assign active  = !b_item_reg.bypass && ({1'b0, level} < depth);
    assign last    = {1'b0, level} == depth - 4'd1;
    assign bit_sel = depth - 4'd2 - {1'b0, level};
    assign pick    = b_item_reg.leaf[bit_sel[2:0]];

    always_comb
    begin
        c_item_next = b_item_reg;
        if (active)
        begin
            if (last)
            begin
                if (b_item_reg.take_mid)
                begin
                    c_item_next.x1 = mx;
                    c_item_next.y1 = my;
                end
            end
            else if (pick)
            begin
                c_item_next.x1 = mx;
                c_item_next.y1 = my;
            end
            else
            begin
                c_item_next.x2 = mx;
                c_item_next.y2 = my;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c_item_reg <= c_item_next;
        end
    end

    assign out_valid = c_valid_reg;
    assign out_item  = c_item_reg;

endmodule

### src/cavg_scale.sv
// Radius scaling and the output register of the result channel.
module cavg_scale (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                adv,
    input  cavg_pkg::cfg_t      cfg,
    input  logic                in_valid,
    input  cavg_pkg::item_t     in_item,
    output logic                out_valid,
    output logic signed [32:0]  x_coord,
    output logic signed [32:0]  y_coord,
    output logic                is_final,
    output logic                past_end
);

    logic               m_valid_reg;
    cavg_pkg::item_t    m_item_reg;
    logic signed [50:0] m_px_reg, m_py_reg;
    logic signed [32:0] radius_s;
    logic signed [32:0] x_next, y_next;
    logic               o_valid_reg;
    logic signed [32:0] x_reg, y_reg;
    logic               final_reg, past_reg;

    assign radius_s = $signed({1'b0, cfg.radius});

    // Product stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            m_valid_reg <= in_valid;
            o_valid_reg <= m_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m_item_reg <= in_item;
            m_px_reg   <= 51'(in_item.x1) * 51'(radius_s);
            m_py_reg   <= 51'(in_item.y1) * 51'(radius_s);
        end
    end

    // Unless noscale, drop the product's fraction bits, rounding down.
    always_comb
    begin
        if (cfg.noscale)
        begin
            x_next = 33'(m_item_reg.x1);
            y_next = 33'(m_item_reg.y1);
        end
        else
        begin
            x_next = m_px_reg[48:16];
            y_next = m_py_reg[48:16];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x_reg     <= x_next;
            y_reg     <= y_next;
            final_reg <= m_item_reg.is_final;
            past_reg  <= m_item_reg.past_end;
        end
    end

    assign out_valid = o_valid_reg;
    assign x_coord   = x_reg;
    assign y_coord   = y_reg;
    assign is_final  = final_reg;
    assign past_end  = past_reg;

endmodule

### src/circle_arc_vertex_generator.sv
// Pipeline: index decode, then stages A, B and C in each of the eight levels, then radius scaling.
// Throughput: one vertex per cycle; the whole pipeline holds while a result waits untaken.
// Each subdivision level has its own reciprocal multiplier pair, so levels overlap freely.
// Reset: asynchronous, active low; radius returns to 1.0, options to zero, pipeline empties.
// Configuration is taken at any time and is read live by the datapath.
module circle_arc_vertex_generator (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [11:0]        vertex_index,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [32:0] x_coord,
    output logic signed [32:0] y_coord,
    output logic               is_final,
    output logic               past_end,
    output logic [11:0]        vertex_total
);

    cavg_pkg::cfg_t  cfg;
    logic            adv;
    logic            lvl_valid [cavg_pkg::MAX_DEPTH+1];
    cavg_pkg::item_t lvl_item  [cavg_pkg::MAX_DEPTH+1];

    // The pipeline advances whenever the output register is free or being taken.
    assign adv      = !out_valid || out_ready;
    assign in_ready = adv;

    cavg_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    cavg_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .adv          (adv),
        .cfg          (cfg),
        .in_valid     (in_valid),
        .vertex_index (vertex_index),
        .total        (vertex_total),
        .out_valid    (lvl_valid[0]),
        .out_item     (lvl_item[0])
    );

    // One pipeline section per subdivision level.
    for (genvar g = 0; g < cavg_pkg::MAX_DEPTH; g++)
    begin : g_level
        cavg_level u_level (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .level     (3'(g)),
            .depth     (cfg.depth),
            .in_valid  (lvl_valid[g]),
            .in_item   (lvl_item[g]),
            .out_valid (lvl_valid[g+1]),
            .out_item  (lvl_item[g+1])
        );
    end

    cavg_scale u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .cfg       (cfg),
        .in_valid  (lvl_valid[cavg_pkg::MAX_DEPTH]),
        .in_item   (lvl_item[cavg_pkg::MAX_DEPTH]),
        .out_valid (out_valid),
        .x_coord   (x_coord),
        .y_coord   (y_coord),
        .is_final  (is_final),
        .past_end  (past_end)
    );

endmodule
